// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hdl/scu_pkg.sv -----
// ----------------------------------------------------------------------------
// scu_pkg
// Types, constants and codes of the stack calculator unit.
// ----------------------------------------------------------------------------
package scu_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int COUNT_OUT_W = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [2:0]        cell_mode_t;

    // operation codes
    localparam op_t OP_PUSH     = 3'd0;
    localparam op_t OP_POP      = 3'd1;
    localparam op_t OP_SUBTRACT = 3'd2;
    localparam op_t OP_MULTIPLY = 3'd3;
    localparam op_t OP_SWAP     = 3'd4;
    localparam op_t OP_NEGATE   = 3'd5;

    // cell update modes
    localparam cell_mode_t MODE_HOLD       = 3'd0;
    localparam cell_mode_t MODE_LOAD       = 3'd1;
    localparam cell_mode_t MODE_FROM_PREV  = 3'd2;
    localparam cell_mode_t MODE_FROM_NEXT1 = 3'd3;
    localparam cell_mode_t MODE_FROM_NEXT2 = 3'd4;

    localparam word_t  EMPTY_WORD = {WORD_W{1'b1}};
    localparam count_t FULL_COUNT = CNT_W'(STACK_DEPTH);

    // control bundle from the operation decoder to the cell row and output stage
    typedef struct packed {
        cell_mode_t mode_top;
        cell_mode_t mode_second;
        cell_mode_t mode_rest;
        word_t      load_top;
        word_t      load_second;
        count_t     count_next;
        word_t      result;
        logic       underflow;
        logic       overflow;
    } ctrl_t;

endpackage

// ----- hdl/scu_cell.sv -----
// ----------------------------------------------------------------------------
// scu_cell
// One stack entry; takes its next word from itself, a load, or a neighbor.
// ----------------------------------------------------------------------------
module scu_cell (
    input  logic               aclk,
    input  scu_pkg::cell_mode_t mode,
    input  scu_pkg::word_t      load_data,
    input  scu_pkg::word_t      prev_data,
    input  scu_pkg::word_t      next1_data,
    input  scu_pkg::word_t      next2_data,
    output scu_pkg::word_t      data
);
    import scu_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb begin
        case (mode)
            MODE_LOAD:       data_next = load_data;
            MODE_FROM_PREV:  data_next = prev_data;
            MODE_FROM_NEXT1: data_next = next1_data;
            MODE_FROM_NEXT2: data_next = next2_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hdl/scu_ctrl.sv -----
// ----------------------------------------------------------------------------
// scu_ctrl
// Operation decoder and ALU: picks operands from the top two cells, computes
// the result and flags, and sets the update mode of every cell.
// ----------------------------------------------------------------------------
module scu_ctrl (
    input  logic            accept,
    input  scu_pkg::op_t    operation,
    input  scu_pkg::word_t  push_value,
    input  scu_pkg::count_t count,
    input  scu_pkg::word_t  top_data,
    input  scu_pkg::word_t  second_data,
    output scu_pkg::ctrl_t  ctrl
);
    import scu_pkg::*;

    logic  have_one;
    logic  have_two;
    word_t opnd_b;
    word_t opnd_a;
    word_t diff;
    word_t prod;
    word_t neg;

    assign have_one = (count != '0);
    assign have_two = (count > CNT_W'(1));
    // missing operands read as minus one
    assign opnd_b   = have_one ? top_data : EMPTY_WORD;
    assign opnd_a   = have_two ? second_data : EMPTY_WORD;
    assign diff     = opnd_a - opnd_b;
    assign prod     = opnd_a * opnd_b;
    assign neg      = word_t'(0) - opnd_b;

    always_comb begin
        ctrl.mode_top    = MODE_HOLD;
        ctrl.mode_second = MODE_HOLD;
        ctrl.mode_rest   = MODE_HOLD;
        ctrl.load_top    = '0;
        ctrl.load_second = '0;
        ctrl.count_next  = count;
        ctrl.result      = '0;
        ctrl.underflow   = 1'b0;
        ctrl.overflow    = 1'b0;
        if (accept) begin
            case (operation)
                OP_PUSH: begin
                    if (count == FULL_COUNT) begin
                        ctrl.overflow = 1'b1;
                    end else begin
                        ctrl.mode_top    = MODE_LOAD;
                        ctrl.mode_second = MODE_FROM_PREV;
                        ctrl.mode_rest   = MODE_FROM_PREV;
                        ctrl.load_top    = push_value;
                        ctrl.count_next  = count + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    ctrl.result    = opnd_b;
                    ctrl.underflow = !have_one;
                    if (have_one) begin
                        ctrl.mode_top    = MODE_FROM_NEXT1;
                        ctrl.mode_second = MODE_FROM_NEXT1;
                        ctrl.mode_rest   = MODE_FROM_NEXT1;
                        ctrl.count_next  = count - CNT_W'(1);
                    end
                end
                OP_SUBTRACT, OP_MULTIPLY: begin
                    // two out, one in: everything below the top two moves up one
                    ctrl.result      = (operation == OP_SUBTRACT) ? diff : prod;
                    ctrl.underflow   = !have_two;
                    ctrl.mode_top    = MODE_LOAD;
                    ctrl.mode_second = MODE_FROM_NEXT1;
                    ctrl.mode_rest   = MODE_FROM_NEXT1;
                    ctrl.load_top    = ctrl.result;
                    ctrl.count_next  = have_two ? count - CNT_W'(1) : CNT_W'(1);
                end
                OP_SWAP: begin
                    ctrl.underflow   = !have_two;
                    ctrl.mode_top    = MODE_LOAD;
                    ctrl.mode_second = MODE_LOAD;
                    ctrl.load_top    = opnd_a;
                    ctrl.load_second = opnd_b;
                    ctrl.count_next  = have_two ? count : CNT_W'(2);
                end
                OP_NEGATE: begin
                    ctrl.result     = neg;
                    ctrl.underflow  = !have_one;
                    ctrl.mode_top   = MODE_LOAD;
                    ctrl.load_top   = neg;
                    ctrl.count_next = have_one ? count : CNT_W'(1);
                end
                default: begin
                    // unused codes leave the stack alone
                    ctrl.count_next = count;
                end
            endcase
        end
    end

endmodule

// ----- hdl/stack_calculator_unit_core.sv -----
// The result word is registered; it appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while m_ready is high; the output register frees
// as the result is taken, so a new word enters in the same cycle.
// Reset clears the entry count and the output valid; stack cells keep
// whatever they hold, and entries above the count are never read.
// ----------------------------------------------------------------------------
// stack_calculator_unit_core
// Bounded integer stack calculator built as a row of shifting cells, the top
// of the stack in cell zero.
// ----------------------------------------------------------------------------
module stack_calculator_unit_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  scu_pkg::op_t                           s_operation,
    input  logic signed [scu_pkg::WORD_W-1:0]      s_push_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [scu_pkg::WORD_W-1:0]      m_result_value,
    output logic                                   m_underflow,
    output logic                                   m_overflow,
    output logic [scu_pkg::COUNT_OUT_W-1:0]        m_stack_count
);
    import scu_pkg::*;

    word_t  cell_q [STACK_DEPTH];
    count_t count_reg;
    logic   accept;
    ctrl_t  ctrl;

    logic   m_valid_reg;
    logic   m_valid_next;
    word_t  result_reg;
    logic   underflow_reg;
    logic   overflow_reg;
    count_t out_count_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    scu_ctrl u_ctrl (
        .accept      (accept),
        .operation   (s_operation),
        .push_value  (word_t'(s_push_value)),
        .count       (count_reg),
        .top_data    (cell_q[0]),
        .second_data (cell_q[1]),
        .ctrl        (ctrl)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        word_t      prev_w;
        word_t      next1_w;
        word_t      next2_w;
        word_t      load_w;
        cell_mode_t mode_w;

        if (i == 0) begin : g_top
            assign prev_w = '0;
            assign load_w = ctrl.load_top;
            assign mode_w = ctrl.mode_top;
        end else if (i == 1) begin : g_second
            assign prev_w = cell_q[i-1];
            assign load_w = ctrl.load_second;
            assign mode_w = ctrl.mode_second;
        end else begin : g_rest
            assign prev_w = cell_q[i-1];
            assign load_w = '0;
            assign mode_w = ctrl.mode_rest;
        end

        if (i + 1 < STACK_DEPTH) begin : g_n1
            assign next1_w = cell_q[i+1];
        end else begin : g_n1_end
            assign next1_w = '0;
        end

        if (i + 2 < STACK_DEPTH) begin : g_n2
            assign next2_w = cell_q[i+2];
        end else begin : g_n2_end
            assign next2_w = '0;
        end

        scu_cell u_cell (
            .aclk       (aclk),
            .mode       (mode_w),
            .load_data  (load_w),
            .prev_data  (prev_w),
            .next1_data (next1_w),
            .next2_data (next2_w),
            .data       (cell_q[i])
        );
    end

    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= ctrl.count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg    <= ctrl.result;
            underflow_reg <= ctrl.underflow;
            overflow_reg  <= ctrl.overflow;
            out_count_reg <= ctrl.count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = result_reg;
    assign m_underflow    = underflow_reg;
    assign m_overflow     = overflow_reg;
    assign m_stack_count  = COUNT_OUT_W'(out_count_reg);

endmodule

// ----- hdl/scu_checker.sv -----
// ----------------------------------------------------------------------------
// scu_checker
// Port-level checks of the stack calculator unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scu_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input scu_pkg::op_t                      s_operation,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [scu_pkg::WORD_W-1:0] m_result_value,
    input logic                              m_underflow,
    input logic                              m_overflow,
    input logic [scu_pkg::COUNT_OUT_W-1:0]   m_stack_count
);
    import scu_pkg::*;

    logic full_w;
    logic push_w;

    assign full_w = (m_stack_count == COUNT_OUT_W'(STACK_DEPTH));
    assign push_w = s_valid && s_ready && (s_operation == OP_PUSH);

    // dropped push only when the stack is full
    `ASSERT_IMPLY(a_overflow_full, aclk, aresetn, m_valid && m_overflow, full_w)

    // a missing operand leaves at most two entries
    `ASSERT_IMPLY(a_underflow_small, aclk, aresetn, m_valid && m_underflow,
        m_stack_count <= COUNT_OUT_W'(2))

    // a push of a word never reports underflow and never leaves the stack empty
    `ASSERT_NEXT(a_push_result, aclk, aresetn, push_w,
        m_valid && !m_underflow && m_stack_count != '0)

    // stalled result holds
    `ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_result_value) && $stable(m_stack_count))

endmodule

bind stack_calculator_unit_core scu_checker u_scu_checker (.*);
